FILE: design/salc_pkg.sv
// salc_pkg: shared types and constants of the set-associative lru cache model
// payload structs, controller command struct, access kinds and register indexes
// no dependencies
package salc_pkg;

  localparam int ADDR_BITS = 48;
  localparam int CNT_W     = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 5;

  localparam logic [1:0] FUNC_LOAD   = 2'd0;
  localparam logic [1:0] FUNC_STORE  = 2'd1;
  localparam logic [1:0] FUNC_MODIFY = 2'd2;
  localparam logic [1:0] FUNC_NONE   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS  = 2'd2;

  typedef struct packed {
    logic [1:0]           func;
    logic [ADDR_BITS-1:0] address;
  } acc_in_t;

  typedef struct packed {
    logic             first_hit;
    logic             first_evicted;
    logic             second_hit;
    logic [CNT_W-1:0] total_hits;
    logic [CNT_W-1:0] total_misses;
    logic [CNT_W-1:0] total_evictions;
  } acc_out_t;

  typedef struct packed {
    logic load;
    logic commit;
  } salc_cmd_t;

endpackage

FILE: design/set_assoc_lru_cache_model.sv
// set_assoc_lru_cache_model: top level of the set-associative lru cache model
// depends on salc_pkg, salc_ctrl, salc_dp
//
// usage: each input transaction (in_valid, in_stall, in_data) is one access:
// load, store, modify or none, with a byte address. one result transaction per
// input leaves on out_valid, out_stall, out_data: hit and eviction flags of
// the access and the running saturating hit, miss and eviction totals.
// geometry is set through cfg_we, cfg_index, cfg_wdata while no access is in
// flight. a taken transaction has its set row read into the ram output
// register, then its update commits to the output register. throughput: one
// access per cycle while the receiver keeps up: the set row is read in the
// accept cycle and written back in the next, in the same cycle as the read
// for the following access (same-set rows are forwarded).
// a modify takes the same time. when the receiver stalls, the result is
// held in the output register and one more access can be read; its update
// waits until the register frees. reset clears the totals, the geometry and
// a per-set flag that makes every set read as empty; no clearing pass.
module set_assoc_lru_cache_model #(
  parameter int MAX_SETS = 64,
  parameter int MAX_WAYS = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  salc_pkg::acc_in_t               in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output salc_pkg::acc_out_t              out_data,
  input  logic                            cfg_we,
  input  logic [salc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [salc_pkg::CFG_W-1:0]      cfg_wdata
);

  salc_pkg::salc_cmd_t cmd;

  salc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  salc_dp #(
    .MAX_SETS (MAX_SETS),
    .MAX_WAYS (MAX_WAYS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_data  (out_data)
  );

endmodule

FILE: design/salc_ram.sv
// salc_ram: generic single write port ram with registered read
// no dependencies
module salc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/salc_ctrl.sv
// salc_ctrl: controller state machine of the cache model
// sequences row read, update and result hand-off; depends on salc_pkg
module salc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  output salc_pkg::salc_cmd_t cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_UPD  = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic can_go;
  logic accept;

  assign can_go   = !out_valid_r || !out_stall;
  assign in_stall = !((state_r == ST_IDLE) || ((state_r == ST_UPD) && can_go));
  assign accept   = in_valid && !in_stall;

  assign cmd.load   = accept;
  assign cmd.commit = (state_r == ST_UPD) && can_go;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        if (can_go) begin
          state_nxt = accept ? ST_UPD : ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_accept_then_upd: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == ST_UPD)
    else $error("accepted transaction not followed by update");

  a_commit_in_upd: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> state_r == ST_UPD)
    else $error("commit outside update state");

  a_accept_in_upd_commits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPD && cmd.load) |-> cmd.commit)
    else $error("new transaction taken before previous one committed");

  a_commit_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r)
    else $error("commit without result");

endmodule

FILE: design/salc_dp.sv
// salc_dp: datapath of the cache model: config registers, set row store,
// hit and victim logic, recency update, saturating totals and result register
// depends on salc_pkg and salc_ram
module salc_dp #(
  parameter int MAX_SETS = 64,
  parameter int MAX_WAYS = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  salc_pkg::salc_cmd_t                 cmd,
  input  salc_pkg::acc_in_t                   in_data,
  input  logic                                cfg_we,
  input  logic [salc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [salc_pkg::CFG_W-1:0]          cfg_wdata,
  output salc_pkg::acc_out_t                  out_data
);

  localparam int SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int RANK_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int AB     = salc_pkg::ADDR_BITS;
  localparam int WAY_W  = 1 + RANK_W + AB;
  localparam int ROW_W  = MAX_WAYS * WAY_W;
  localparam int CW     = salc_pkg::CNT_W;
  localparam logic [RANK_W:0] RANK_TOP = (RANK_W + 1)'(MAX_WAYS - 1);
  localparam logic [RANK_W:0] RANK_NEW = (RANK_W + 1)'(MAX_WAYS);

  function automatic logic [SET_W-1:0] set_of(input logic [6:0] idx);
    logic [SET_W-1:0] r;
    r = '0;
    for (int i = 0; i < 128; i++) begin
      if (idx == 7'(i)) begin
        r = SET_W'(i % MAX_SETS);
      end
    end
    return r;
  endfunction

  function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] v, input logic [1:0] inc);
    logic [CW:0] s;
    s = {1'b0, v} + {{(CW - 1){1'b0}}, inc};
    return s[CW] ? {CW{1'b1}} : s[CW-1:0];
  endfunction

  // configuration
  logic [2:0] set_bits_r;
  logic [3:0] ways_r;
  logic [4:0] block_bits_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_bits_r   <= 3'd0;
      ways_r       <= 4'd1;
      block_bits_r <= 5'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        salc_pkg::CFG_SET_BITS:    set_bits_r   <= cfg_wdata[2:0];
        salc_pkg::CFG_WAYS_IN_USE: ways_r       <= cfg_wdata[3:0];
        salc_pkg::CFG_BLOCK_BITS:  block_bits_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // address split at accept
  logic [AB-1:0]    shifted;
  logic [6:0]       idx_mask;
  logic [6:0]       idx;
  logic [AB-1:0]    tag_in;
  logic [SET_W-1:0] rd_set;
  logic [5:0]       tag_sh;

  assign shifted  = in_data.address >> block_bits_r;
  assign idx_mask = 7'((8'd1 << set_bits_r) - 8'd1);
  assign idx      = shifted[6:0] & idx_mask;
  assign tag_sh   = {1'b0, block_bits_r} + {3'd0, set_bits_r};
  assign tag_in   = in_data.address >> tag_sh;
  assign rd_set   = set_of(idx);

  // row store with per-row init flags
  logic [MAX_SETS-1:0] row_init_r;
  logic [ROW_W-1:0]    ram_q;
  logic                wr_en;
  logic [ROW_W-1:0]    wr_row;
  logic [SET_W-1:0]    set_r;
  logic [1:0]          func_r;
  logic [AB-1:0]       tag_r;
  logic                row_vld_r;
  logic                byp_r;
  logic [ROW_W-1:0]    byp_row_r;
  logic                same_row;

  salc_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_SETS)
  ) u_rows (
    .clk   (clk),
    .we    (wr_en),
    .waddr (set_r),
    .wdata (wr_row),
    .re    (cmd.load),
    .raddr (rd_set),
    .rdata (ram_q)
  );

  assign same_row = wr_en && (set_r == rd_set);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_init_r <= '0;
    end else if (wr_en) begin
      row_init_r[set_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      set_r     <= rd_set;
      func_r    <= in_data.func;
      tag_r     <= tag_in;
      row_vld_r <= row_init_r[rd_set] || same_row;
      byp_r     <= same_row;
      byp_row_r <= wr_row;
    end
  end

  // unpack current row
  logic [ROW_W-1:0]  cur_row;
  logic              v   [MAX_WAYS];
  logic [RANK_W-1:0] rk  [MAX_WAYS];
  logic [AB-1:0]     tg  [MAX_WAYS];
  logic              use_w [MAX_WAYS];

  assign cur_row = byp_r ? byp_row_r : (row_vld_r ? ram_q : '0);

  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      tg[w]    = cur_row[w * WAY_W +: AB];
      rk[w]    = cur_row[w * WAY_W + AB +: RANK_W];
      v[w]     = cur_row[w * WAY_W + AB + RANK_W];
      use_w[w] = (w == 0) || ({1'b0, ways_r} > 5'(w));
    end
  end

  // lookup and replacement
  logic              acc;
  logic              hit;
  logic              have_empty;
  logic              evicted;
  logic [RANK_W-1:0] best;
  logic [RANK_W:0]   old_rank;
  logic [RANK_W-1:0] hit_way;
  logic [RANK_W-1:0] empty_way;
  logic [RANK_W-1:0] victim;
  logic [RANK_W-1:0] sel;

  always_comb begin
    hit        = 1'b0;
    hit_way    = '0;
    have_empty = 1'b0;
    empty_way  = '0;
    victim     = '0;
    best       = rk[0];
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (use_w[w] && v[w] && (tg[w] == tag_r)) begin
        hit     = 1'b1;
        hit_way = RANK_W'(w);
      end
    end
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (use_w[w] && !v[w]) begin
        have_empty = 1'b1;
        empty_way  = RANK_W'(w);
      end
      if (use_w[w] && (rk[w] > best)) begin
        best   = rk[w];
        victim = RANK_W'(w);
      end
    end
  end

  assign acc     = (func_r != salc_pkg::FUNC_NONE);
  assign evicted = acc && !hit && !have_empty;

  always_comb begin
    if (hit) begin
      sel      = hit_way;
      old_rank = {1'b0, rk[hit_way]};
    end else if (have_empty) begin
      sel      = empty_way;
      old_rank = RANK_NEW;
    end else begin
      sel      = victim;
      old_rank = {1'b0, best};
    end
  end

  always_comb begin
    wr_row = cur_row;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (sel == RANK_W'(w)) begin
        wr_row[w * WAY_W + AB +: RANK_W] = '0;
        wr_row[w * WAY_W + AB + RANK_W]  = 1'b1;
        wr_row[w * WAY_W +: AB]          = tag_r;
      end else if (use_w[w] && v[w] && ({1'b0, rk[w]} < old_rank)
                   && ({1'b0, rk[w]} < RANK_TOP)) begin
        wr_row[w * WAY_W + AB +: RANK_W] = rk[w] + 1'b1;
      end
    end
  end

  assign wr_en = cmd.commit && acc;

  // totals and result register
  logic [CW-1:0] hits_r, misses_r, evicts_r;
  logic [CW-1:0] hits_nxt, misses_nxt, evicts_nxt;
  logic [1:0]    hit_inc;
  logic          second;

  assign second     = (func_r == salc_pkg::FUNC_MODIFY);
  assign hit_inc    = {1'b0, acc && hit} + {1'b0, second};
  assign hits_nxt   = sat_add(hits_r, hit_inc);
  assign misses_nxt = sat_add(misses_r, {1'b0, acc && !hit});
  assign evicts_nxt = sat_add(evicts_r, {1'b0, evicted});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hits_r   <= '0;
      misses_r <= '0;
      evicts_r <= '0;
    end else if (cmd.commit) begin
      hits_r   <= hits_nxt;
      misses_r <= misses_nxt;
      evicts_r <= evicts_nxt;
    end
  end

  salc_pkg::acc_out_t out_r;

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_r.first_hit       <= acc && hit;
      out_r.first_evicted   <= evicted;
      out_r.second_hit      <= second;
      out_r.total_hits      <= hits_nxt;
      out_r.total_misses    <= misses_nxt;
      out_r.total_evictions <= evicts_nxt;
    end
  end

  assign out_data = out_r;

endmodule
